// ----- sv/rbba_pkg.sv -----
// shared types, widths and codes of the ring buffer block allocator
package rbba_pkg;

    localparam int unsigned W_ADDR  = 25;
    localparam int unsigned W_ALIGN = 17;
    localparam int unsigned W_KIND  = 2;
    localparam int unsigned W_STAT  = 3;

    localparam int unsigned DEF_BLOCK_FIFO_DEPTH = 8;
    localparam logic [W_ADDR-1:0] RESET_TOTAL_SIZE = W_ADDR'(65536);

    typedef logic [W_ADDR-1:0]  t_addr;
    typedef logic [W_ALIGN-1:0] t_align;

    typedef enum logic [W_KIND-1:0] {
        K_ALLOC = 2'd0,
        K_MARK  = 2'd1,
        K_FREE  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [W_STAT-1:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_FIFO_FULL  = 3'd2,
        ST_FIFO_EMPTY = 3'd3,
        ST_BAD_ALIGN  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_DIV,
        S_EVAL,
        S_FETCH,
        S_DONE
    } t_state;

    // one closed block as held in the block memory
    typedef struct packed {
        t_addr blk_begin;
        t_addr blk_end;
    } t_block;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic rd_en;
    } t_fifo_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

// ----- sv/rbba_if.sv -----
// handshake interfaces for the request, result and size register channels

interface rbba_req_if;
    import rbba_pkg::*;
    logic   valid;
    logic   ready;
    logic [W_KIND-1:0] kind;
    t_addr  size;
    t_align alignment;

    modport source (output valid, kind, size, alignment, input ready);
    modport sink   (input valid, kind, size, alignment, output ready);
endinterface

interface rbba_rsp_if;
    import rbba_pkg::*;
    logic  valid;
    logic  ready;
    logic [W_STAT-1:0] status;
    t_addr offset;
    t_addr block_end;
    t_addr freed_bytes;
    t_addr remaining_bytes;

    modport source (output valid, status, offset, block_end, freed_bytes,
                    remaining_bytes, input ready);
    modport sink   (input valid, status, offset, block_end, freed_bytes,
                    remaining_bytes, output ready);
endinterface

interface rbba_cfg_if;
    import rbba_pkg::*;
    logic  valid;
    logic  ready;
    t_addr data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/rbba_rem_unit.sv -----
// bit-serial remainder unit, one dividend bit per cycle
module rbba_rem_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rbba_pkg::t_addr  i_dividend,
    input  rbba_pkg::t_align i_divisor,
    output logic            o_done,
    output rbba_pkg::t_align o_rem
);
    import rbba_pkg::*;

    localparam int unsigned CNT_W = $clog2(W_ADDR + 1);

    t_addr            r_dvd;
    t_align           r_dsr;
    t_align           r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W_ALIGN:0] trial;
    logic [W_ALIGN:0] shifted;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        shifted = {r_rem, r_dvd[W_ADDR-1]};
        if (shifted >= {1'b0, r_dsr}) begin
            trial = shifted - {1'b0, r_dsr};
        end else begin
            trial = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(W_ADDR);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[W_ADDR-2:0], 1'b0};
            r_rem <= trial[W_ALIGN-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- sv/rbba_block_fifo.sv -----
// block fifo: one synchronous memory of closed blocks with head, tail and count
module rbba_block_fifo #(
    parameter int unsigned DEPTH = rbba_pkg::DEF_BLOCK_FIFO_DEPTH,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbba_pkg::t_fifo_ctrl i_ctrl,
    input  rbba_pkg::t_block     i_wr_data,
    output rbba_pkg::t_block     o_rd_data,
    output rbba_pkg::t_fifo_stat o_stat,
    output logic [CNT_W-1:0]     o_count
);
    import rbba_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_block           mem [DEPTH];
    t_block           r_rd_data;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_tail] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_tail <= next_slot(r_tail);
            end
            if (i_ctrl.pop) begin
                r_head <= next_slot(r_head);
            end
            if (i_ctrl.push && !i_ctrl.pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctrl.pop && !i_ctrl.push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_count      = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

endmodule

// ----- sv/ring_buffer_block_allocator.sv -----
// top level of the ring buffer block allocator
//
// hands out aligned byte ranges from a ring of total_size bytes and keeps the
// closed blocks in a fifo memory until they are freed. one request word is
// taken at a time: the request port is ready whenever the sequencer is idle,
// also while the previous result word still waits in the output register.
// a mark, an unused kind or a free on an empty fifo go from the accept
// straight to the done state. a free first reads the block memory and then
// sums the block length. an allocate refused at the wrap check (zero
// alignment, or a skipped tail beyond the free count) goes from there to
// the done state, and any other allocate passes the accept, the wrap check,
// the bit-serial remainder unit that works out the alignment padding at one
// address bit per cycle, the remainder hand-over, the range check and the
// commit. the done state waits for a free output register. writing the
// size register empties the ring at once (fifo pointers cleared, contents
// left) and is taken on any cycle, but is meant for an idle block. zero
// alignment, no space, a full fifo on mark or an empty fifo on free return
// an error status with the state left as it was.
module ring_buffer_block_allocator #(
    parameter int unsigned BLOCK_FIFO_DEPTH = rbba_pkg::DEF_BLOCK_FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbba_req_if.sink   i_req,
    rbba_rsp_if.source o_rsp,
    rbba_cfg_if.sink   i_cfg
);
    import rbba_pkg::*;

    localparam int unsigned CNT_W = $clog2(BLOCK_FIFO_DEPTH + 1);

    // sequencer and ring state
    t_state  r_state, n_state;
    t_addr   r_total;
    t_addr   r_open_begin;
    t_addr   r_open_end;
    t_addr   r_free;

    // request being worked on
    t_kind   r_kind, n_kind;
    t_addr   r_size, n_size;
    t_align  r_align, n_align;
    t_addr   r_cur, n_cur;
    t_addr   r_avail, n_avail;
    t_align  r_pad, n_pad;

    // result and next state values, committed in the done state
    t_status r_status, n_status;
    t_addr   r_offset, n_offset;
    t_addr   r_bend, n_bend;
    t_addr   r_freed, n_freed;
    t_addr   r_new_free, n_new_free;
    t_addr   r_new_begin, n_new_begin;
    t_addr   r_new_end, n_new_end;

    // output register
    logic    r_out_valid;
    t_status r_out_status;
    t_addr   r_out_offset;
    t_addr   r_out_bend;
    t_addr   r_out_freed;
    t_addr   r_out_remain;

    logic       req_acc;
    logic       cfg_acc;
    logic       out_free;
    logic       commit;
    logic       rem_start;
    logic       rem_done;
    t_align     rem_val;
    t_fifo_ctrl fifo_ctrl;
    t_fifo_stat fifo_stat;
    t_block     fifo_wr;
    t_block     fifo_rd;
    logic [CNT_W-1:0] fifo_count;

    // wide intermediates of the allocate and free paths
    logic [W_ADDR+1:0] span_end;
    t_addr             tail_bytes;
    logic [W_ADDR:0]   pos;
    logic [W_ADDR+1:0] pos_end;
    logic [W_ADDR:0]   charge;
    logic [W_ADDR+1:0] wrap_len;
    t_addr             blk_len;
    logic [W_ADDR:0]   free_sum;

    assign req_acc  = i_req.valid && i_req.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign commit   = (r_state == S_DONE) && out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    rbba_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (n_cur),
        .i_divisor  (r_align),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    rbba_block_fifo #(
        .DEPTH (BLOCK_FIFO_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (fifo_ctrl),
        .i_wr_data (fifo_wr),
        .o_rd_data (fifo_rd),
        .o_stat    (fifo_stat),
        .o_count   (fifo_count)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    case (t_kind'(i_req.kind))
                        K_ALLOC: n_state = S_WRAP;
                        K_FREE:  n_state = fifo_stat.empty ? S_DONE : S_FETCH;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WRAP: begin
                n_state = (n_status == ST_OK) ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (rem_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL:  n_state = S_DONE;
            S_FETCH: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_kind      = r_kind;
        n_size      = r_size;
        n_align     = r_align;
        n_cur       = r_cur;
        n_avail     = r_avail;
        n_pad       = r_pad;
        n_status    = r_status;
        n_offset    = r_offset;
        n_bend      = r_bend;
        n_freed     = r_freed;
        n_new_free  = r_new_free;
        n_new_begin = r_new_begin;
        n_new_end   = r_new_end;
        rem_start   = 1'b0;
        fifo_ctrl   = '0;

        span_end   = {2'b00, r_open_end} + {2'b00, r_size}
                   + {{(W_ADDR-W_ALIGN+2){1'b0}}, r_align};
        tail_bytes = (r_total > r_open_end) ? (r_total - r_open_end) : '0;
        pos        = {1'b0, r_cur} + {{(W_ADDR-W_ALIGN+1){1'b0}}, r_pad};
        pos_end    = {1'b0, pos} + {2'b00, r_size};
        charge     = {{(W_ADDR-W_ALIGN+1){1'b0}}, r_pad} + {1'b0, r_size};
        wrap_len   = {2'b00, fifo_rd.blk_end} + {2'b00, r_total}
                   - {2'b00, fifo_rd.blk_begin};
        blk_len    = (fifo_rd.blk_end >= fifo_rd.blk_begin)
                   ? (fifo_rd.blk_end - fifo_rd.blk_begin) : wrap_len[W_ADDR-1:0];
        free_sum   = {1'b0, r_free} + {1'b0, blk_len};

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_kind      = t_kind'(i_req.kind);
                    n_size      = i_req.size;
                    n_align     = i_req.alignment;
                    n_status    = ST_OK;
                    n_offset    = '0;
                    n_bend      = '0;
                    n_freed     = '0;
                    n_new_free  = r_free;
                    n_new_begin = r_open_begin;
                    n_new_end   = r_open_end;
                    case (t_kind'(i_req.kind))
                        K_MARK: begin
                            if (fifo_stat.full) begin
                                n_status = ST_FIFO_FULL;
                            end else begin
                                n_offset    = r_open_begin;
                                n_bend      = r_open_end;
                                // a block that ends at the top restarts at 0
                                n_new_begin = (r_open_end == r_total) ? '0 : r_open_end;
                                n_new_end   = (r_open_end == r_total) ? '0 : r_open_end;
                            end
                        end
                        K_FREE: begin
                            if (fifo_stat.empty) begin
                                n_status = ST_FIFO_EMPTY;
                            end else begin
                                fifo_ctrl.rd_en = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WRAP: begin
                n_cur   = r_open_end;
                n_avail = r_free;
                if (r_align == '0) begin
                    n_status = ST_BAD_ALIGN;
                end else if (span_end > {2'b00, r_total}) begin
                    // wrap to 0, the skipped tail is charged
                    if (tail_bytes > r_free) begin
                        n_status = ST_NO_SPACE;
                    end else begin
                        n_avail   = r_free - tail_bytes;
                        n_cur     = '0;
                        rem_start = 1'b1;
                    end
                end else begin
                    rem_start = 1'b1;
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    n_pad = (rem_val == '0) ? '0 : (r_align - rem_val);
                end
            end
            S_EVAL: begin
                if (pos_end > {2'b00, r_total} || charge > {1'b0, r_avail}) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    n_offset   = pos[W_ADDR-1:0];
                    n_new_free = r_avail - charge[W_ADDR-1:0];
                    n_new_end  = pos_end[W_ADDR-1:0];
                end
            end
            S_FETCH: begin
                n_offset   = fifo_rd.blk_begin;
                n_bend     = fifo_rd.blk_end;
                n_freed    = blk_len;
                // saturate at the ring size
                n_new_free = (free_sum > {1'b0, r_total}) ? r_total : free_sum[W_ADDR-1:0];
            end
            S_DONE: begin
                if (out_free && r_status == ST_OK) begin
                    fifo_ctrl.push = (r_kind == K_MARK);
                    fifo_ctrl.pop  = (r_kind == K_FREE);
                end
            end
            default: ;
        endcase

        fifo_ctrl.clear = cfg_acc;
    end

    assign fifo_wr.blk_begin = r_open_begin;
    assign fifo_wr.blk_end   = r_open_end;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_total      <= RESET_TOTAL_SIZE;
            r_free       <= RESET_TOTAL_SIZE;
            r_open_begin <= '0;
            r_open_end   <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                r_total      <= i_cfg.data;
                r_free       <= i_cfg.data;
                r_open_begin <= '0;
                r_open_end   <= '0;
            end else if (commit) begin
                r_free       <= r_new_free;
                r_open_begin <= r_new_begin;
                r_open_end   <= r_new_end;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_size      <= n_size;
        r_align     <= n_align;
        r_cur       <= n_cur;
        r_avail     <= n_avail;
        r_pad       <= n_pad;
        r_status    <= n_status;
        r_offset    <= n_offset;
        r_bend      <= n_bend;
        r_freed     <= n_freed;
        r_new_free  <= n_new_free;
        r_new_begin <= n_new_begin;
        r_new_end   <= n_new_end;
        if (commit) begin
            r_out_status <= r_status;
            r_out_offset <= r_offset;
            r_out_bend   <= r_bend;
            r_out_freed  <= r_freed;
            r_out_remain <= r_new_free;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.offset          = r_out_offset;
    assign o_rsp.block_end       = r_out_bend;
    assign o_rsp.freed_bytes     = r_out_freed;
    assign o_rsp.remaining_bytes = r_out_remain;

    // checks
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= CNT_W'(BLOCK_FIFO_DEPTH))
        else $error("block fifo count beyond depth");

    a_remain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.remaining_bytes <= r_total))
        else $error("free count beyond ring size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle right after taking a request");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
        (o_rsp.offset == '0 && o_rsp.block_end == '0 && o_rsp.freed_bytes == '0))
        else $error("error result carries block fields");

endmodule
